### src/shng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shng_pkg - shared types and constants for the sample-and-hold noise source
// Register indexes, mode codes, divider request/response records and the
// fixed-point constants used by the datapath.
// ----------------------------------------------------------------------------
package shng_pkg;

    // Field widths
    localparam int LEVEL_W = 16;   // input levels, signed mV
    localparam int OUT_W   = 32;   // held level, signed Q.16 mV
    localparam int TICK_W  = 15;   // tick counter and hold length
    localparam int CFG_W   = 32;   // widest configuration register
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_X100  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 2'd2;

    // Noise modes
    localparam logic [1:0] MODE_WHITE   = 2'd0;
    localparam logic [1:0] MODE_BROWN   = 2'd1;
    localparam logic [1:0] MODE_TRIGGER = 2'd2;

    // Random source
    localparam logic [31:0] LFSR_TAPS  = 32'hA300_0000;
    localparam logic [31:0] LFSR_RESET = 32'h0000_0001;

    // Arithmetic constants
    localparam logic [TICK_W-1:0]        PERIOD_DIVISOR   = 15'd100;
    localparam logic signed [LEVEL_W-1:0] TRIGGER_SCALE   = 16'sd10000;
    localparam logic [OUT_W-1:0]         TRIGGER_HIGH_Q16 = 32'd65536000;

    // Reciprocals: floor(n / 100) = (n * 5243) >> 19 for n below 43690,
    // floor(n / 10) = (n * 0xCCCCCCCD) >> 35 for n below 2^34
    localparam logic signed [LEVEL_W-1:0] PERIOD_RECIP    = 16'sd5243;
    localparam int                        PERIOD_RECIP_SHIFT = 19;
    localparam logic [OUT_W-1:0]          BROWN_RECIP     = 32'hCCCC_CCCD;
    localparam int                        BROWN_RECIP_SHIFT  = 35;

    // Shared divider
    localparam int DIV_DVD_W = 32;
    localparam int DIV_DSR_W = TICK_W;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_TICK = 6'd15;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;     // quotient bits to produce
        logic [DIV_DVD_W-1:0] dividend;  // left aligned: MSB of operand at top
        logic [DIV_DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
        logic [DIV_DSR_W-1:0] remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

### src/shng_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shng_divider - shared iterative restoring divider
// Produces one quotient bit per cycle; the dividend arrives left aligned so
// a short operand needs only as many steps as it has bits.
// ----------------------------------------------------------------------------
module shng_divider (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  shng_pkg::div_req_t  req,
    output shng_pkg::div_rsp_t  rsp
);

    logic [shng_pkg::DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [shng_pkg::DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [shng_pkg::DIV_DSR_W-1:0] dsr_reg, dsr_next;
    logic [shng_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [shng_pkg::DIV_DSR_W:0]   shifted;
    logic [shng_pkg::DIV_DSR_W:0]   diff;
    logic                           fits;

    // Bring down the next dividend bit and trial-subtract
    assign shifted = {rem_reg, quo_reg[shng_pkg::DIV_DVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[shng_pkg::DIV_DVD_W-2:0], fits};
            rem_next = fits ? diff[shng_pkg::DIV_DSR_W-1:0]
                            : shifted[shng_pkg::DIV_DSR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

### src/shng_lfsr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shng_lfsr - 32-bit Galois LFSR random source
// Shifts right once per step request; a zero seed loads as one.
// ----------------------------------------------------------------------------
module shng_lfsr (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         load,
    input  wire  [31:0] seed,
    input  wire         step,
    output logic [31:0] value
);

    logic [31:0] lfsr_reg, lfsr_next;

    always_comb begin
        lfsr_next = lfsr_reg;
        if (load) begin
            lfsr_next = (seed == '0) ? shng_pkg::LFSR_RESET : seed;
        end else if (step) begin
            lfsr_next = {1'b0, lfsr_reg[31:1]};
            if (lfsr_reg[0]) begin
                lfsr_next = lfsr_next ^ shng_pkg::LFSR_TAPS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= shng_pkg::LFSR_RESET;
        end else begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign value = lfsr_reg;

endmodule
`default_nettype wire

### src/sample_hold_noise_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_hold_noise_generator - sample-and-hold random noise source
// One input beat is one sample tick; one output beat carries the held level.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Payload (lowest bit first)
//  s_axis    | in        | period_level_mv[15:0], volume_level_mv[31:16]
//  m_axis    | out       | noise_out[31:0] (signed Q.16 mV)
//  cfg_wr    | in        | index 0 noise_mode, 1 period_times_hundred, 2 random_seed
//
// An item takes longest with period / 100 and a brownian step. Whenever the
// hold length exceeds one, the counter modulo runs on the shared divider,
// one remainder bit per cycle, while the sequencer waits for its result.
// Reset is synchronous and active low; it clears the counter, the held level,
// the configuration, and loads the LFSR with one. s_axis_tready is high only
// while idle; a finished beat waits in the output register, so the next beat
// is taken while m_axis is stalled.
// ----------------------------------------------------------------------------
module sample_hold_noise_generator (
    input  wire         aclk,
    input  wire         aresetn,

    // Input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] period_level_mv, [31:16] volume_level_mv

    // Result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] noise_out

    // Configuration writes
    input  wire                                cfg_wr_en,
    input  wire  [shng_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire  [shng_pkg::CFG_W-1:0]         cfg_wr_data
);

    // Sequencer states
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_LEN        = 4'd1;
    localparam logic [3:0] S_LEN_WAIT   = 4'd2;
    localparam logic [3:0] S_TICK       = 4'd3;
    localparam logic [3:0] S_TICK_WAIT  = 4'd4;
    localparam logic [3:0] S_DRAW       = 4'd5;
    localparam logic [3:0] S_MUL        = 4'd6;
    localparam logic [3:0] S_APPLY      = 4'd7;
    localparam logic [3:0] S_BROWN_WAIT = 4'd8;
    localparam logic [3:0] S_OUT        = 4'd9;
    localparam logic [3:0] S_BROWN_MUL  = 4'd10;

    localparam int LW = shng_pkg::LEVEL_W;
    localparam int TW = shng_pkg::TICK_W;
    localparam int OW = shng_pkg::OUT_W;
    localparam int PW = 34;   // product and walk sum width

    // Configuration
    logic [1:0] mode_reg;
    logic       x100_reg;

    // Sequencer and datapath
    logic [3:0]           state_reg, state_next;
    logic [TW-1:0]        len_reg, len_next;
    logic [TW-1:0]        tick_reg, tick_next;
    logic [OW-1:0]        held_reg, held_next;
    logic signed [PW-1:0] prod_reg;
    logic [OW-1:0]        mag_reg;
    logic [OW-1:0]        brown_q_reg;
    logic [LW-1:0]        period_reg;
    logic [LW-1:0]        vol_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [OW-1:0]        m_data_reg, m_data_next;

    shng_pkg::div_req_t   div_req;
    shng_pkg::div_rsp_t   div_rsp;
    logic                 lfsr_load;
    logic                 lfsr_step;
    logic [31:0]          lfsr_value;

    logic                 in_accept;
    logic [TW-1:0]        rem_inc;
    logic [15:0]          rnd_u;
    logic signed [17:0]   mul_a;
    logic signed [LW-1:0] mul_b;
    logic signed [PW-1:0] vol16;
    logic signed [PW-1:0] prod_mag;
    logic [2*OW-1:0]      brown_prod;
    logic signed [PW-1:0] delta;
    logic signed [PW-1:0] walk_sum;
    logic signed [PW-1:0] walk_low;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Configuration registers; the seed goes straight into the LFSR
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= shng_pkg::MODE_WHITE;
            x100_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                shng_pkg::REG_NOISE_MODE:  mode_reg <= cfg_wr_data[1:0];
                shng_pkg::REG_PERIOD_X100: x100_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign lfsr_load = cfg_wr_en && (cfg_wr_index == shng_pkg::REG_RANDOM_SEED);

    shng_lfsr u_lfsr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (lfsr_load),
        .seed    (cfg_wr_data),
        .step    (lfsr_step),
        .value   (lfsr_value)
    );

    shng_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign rem_inc = div_rsp.remainder + {{(TW-1){1'b0}}, 1'b1};
    assign rnd_u   = lfsr_value[31:16];
    assign vol16   = $signed({{(PW-LW-16){vol_reg[LW-1]}}, vol_reg, 16'b0});

    // One multiplier: u*V (white), (2u-65536)*V (brownian), u*10000 (trigger),
    // and period times the reciprocal of 100 while the hold length is formed
    always_comb begin
        mul_a = $signed({2'b00, rnd_u});
        mul_b = $signed(vol_reg);
        case (mode_reg)
            shng_pkg::MODE_BROWN:   mul_a = $signed({1'b0, rnd_u, 1'b0}) - 18'sd65536;
            shng_pkg::MODE_TRIGGER: mul_b = shng_pkg::TRIGGER_SCALE;
            default: ;
        endcase
        if (state_reg == S_LEN) begin
            mul_a = $signed({3'b000, period_reg[TW-1:0]});
            mul_b = shng_pkg::PERIOD_RECIP;
        end
    end

    // Brownian step: divide |product| by ten, truncate toward zero, restore sign
    assign prod_mag   = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign brown_prod = mag_reg * shng_pkg::BROWN_RECIP;
    assign delta      = prod_reg[PW-1] ? -$signed({2'b00, brown_q_reg})
                                       :  $signed({2'b00, brown_q_reg});
    assign walk_sum = $signed({{(PW-OW){held_reg[OW-1]}}, held_reg}) + delta;
    // Lower bound first, then the upper bound at V
    assign walk_low = walk_sum[PW-1] ? '0 : walk_sum;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        tick_next    = tick_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        lfsr_step    = 1'b0;
        div_req      = '0;

        // Drop the waiting beat once the sink takes it
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_LEN;
                end
            end

            // Hold length: period as is, or period / 100, never below one
            S_LEN: begin
                if (x100_reg) begin
                    len_next = (period_reg[LW-1] || period_reg == '0)
                             ? {{(TW-1){1'b0}}, 1'b1} : period_reg[TW-1:0];
                    state_next = S_TICK;
                end else if ($signed(period_reg) < $signed({1'b0, shng_pkg::PERIOD_DIVISOR})) begin
                    len_next   = {{(TW-1){1'b0}}, 1'b1};
                    state_next = S_TICK;
                end else begin
                    state_next = S_LEN_WAIT;
                end
            end

            // Take the quotient from the top of the reciprocal product
            S_LEN_WAIT: begin
                len_next   = prod_reg[PW-1:shng_pkg::PERIOD_RECIP_SHIFT];
                state_next = S_TICK;
            end

            // Counter modulo hold length
            S_TICK: begin
                if (len_reg == {{(TW-1){1'b0}}, 1'b1}) begin
                    tick_next  = '0;
                    state_next = S_DRAW;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.steps    = shng_pkg::DIV_STEPS_TICK;
                    div_req.dividend = {tick_reg, {(32-TW){1'b0}}};
                    div_req.divisor  = len_reg;
                    state_next       = S_TICK_WAIT;
                end
            end

            S_TICK_WAIT: begin
                if (div_rsp.done) begin
                    tick_next  = (rem_inc == len_reg) ? '0 : rem_inc;
                    state_next = (div_rsp.remainder == '0) ? S_DRAW : S_OUT;
                end
            end

            // Advance the LFSR once for a fresh draw
            S_DRAW: begin
                lfsr_step  = 1'b1;
                state_next = S_MUL;
            end

            S_MUL: begin
                state_next = S_APPLY;
            end

            S_APPLY: begin
                state_next = S_OUT;
                case (mode_reg)
                    shng_pkg::MODE_WHITE: begin
                        held_next = prod_reg[OW-1:0];
                    end
                    shng_pkg::MODE_TRIGGER: begin
                        held_next = (prod_reg > vol16) ? shng_pkg::TRIGGER_HIGH_Q16 : '0;
                    end
                    shng_pkg::MODE_BROWN: begin
                        state_next = S_BROWN_MUL;
                    end
                    default: ;   // undefined mode: hold the level
                endcase
            end

            // Magnitude is registered; the reciprocal product lands next
            S_BROWN_MUL: begin
                state_next = S_BROWN_WAIT;
            end

            S_BROWN_WAIT: begin
                held_next  = (walk_low > vol16) ? vol16[OW-1:0] : walk_low[OW-1:0];
                state_next = S_OUT;
            end

            // Hand the level to the output register once it is free
            S_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = held_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tick_reg    <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg     <= len_next;
        m_data_reg  <= m_data_next;
        prod_reg    <= mul_a * mul_b;
        mag_reg     <= prod_mag[OW-1:0];
        brown_q_reg <= OW'(brown_prod >> shng_pkg::BROWN_RECIP_SHIFT);
        if (in_accept) begin
            period_reg <= s_axis_tdata[LW-1:0];
            vol_reg    <= s_axis_tdata[2*LW-1:LW];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
`default_nettype wire
